FILE: rtl/fqs_pkg.sv
`default_nettype none

package fqs_pkg;

   // Character codes used by the parser
   localparam logic [7:0] ChrLf    = 8'h0A;
   localparam logic [7:0] ChrCr    = 8'h0D;
   localparam logic [7:0] ChrDquot = 8'h22;
   localparam logic [7:0] ChrPct   = 8'h25;
   localparam logic [7:0] ChrAmp   = 8'h26;
   localparam logic [7:0] ChrSemi  = 8'h3B;
   localparam logic [7:0] ChrLt    = 8'h3C;
   localparam logic [7:0] ChrGt    = 8'h3E;
   localparam logic [7:0] ChrA     = 8'h61;
   localparam logic [7:0] ChrB     = 8'h62;
   localparam logic [7:0] ChrG     = 8'h67;
   localparam logic [7:0] ChrL     = 8'h6C;
   localparam logic [7:0] ChrM     = 8'h6D;
   localparam logic [7:0] ChrO     = 8'h6F;
   localparam logic [7:0] ChrP     = 8'h70;
   localparam logic [7:0] ChrQ     = 8'h71;
   localparam logic [7:0] ChrR     = 8'h72;
   localparam logic [7:0] ChrT     = 8'h74;
   localparam logic [7:0] ChrU     = 8'h75;

   // Result kinds on rsp_tuser
   localparam logic KindText     = 1'b0;
   localparam logic KindQuoteEnd = 1'b1;

   // How one text character is rendered
   typedef enum logic [2:0] {
      CHR_NONE = 3'd0,
      CHR_BYTE = 3'd1,
      CHR_BR   = 3'd2,
      CHR_QUOT = 3'd3,
      CHR_AMP  = 3'd4,
      CHR_LT   = 3'd5,
      CHR_GT   = 3'd6
   } chr_type;

   // Work for one accepted word: optional <br> prefix, at most one character, optional quote end
   typedef struct packed {
      logic       br_pre;
      chr_type    chr;
      logic [7:0] txt;
      logic       end_mark;
   } plan_type;

   // Number of bytes a rendered character takes
   function automatic logic [3:0] chr_len(input chr_type chr);
      logic [3:0] n;
      begin
         unique case (chr)
            CHR_NONE: n = 4'd0;
            CHR_BYTE: n = 4'd1;
            CHR_BR:   n = 4'd4;
            CHR_QUOT: n = 4'd6;
            CHR_AMP:  n = 4'd5;
            CHR_LT:   n = 4'd4;
            CHR_GT:   n = 4'd4;
            default:  n = 4'd0;
         endcase
         return n;
      end
   endfunction

   // Byte at position pos of a rendered character
   function automatic logic [7:0] chr_at(input chr_type chr, input logic [2:0] pos,
                                         input logic [7:0] txt);
      logic [7:0] b;
      begin
         b = txt;
         unique case (chr)
            CHR_BR: begin
               unique case (pos)
                  3'd0:    b = ChrLt;
                  3'd1:    b = ChrB;
                  3'd2:    b = ChrR;
                  default: b = ChrGt;
               endcase
            end
            CHR_QUOT: begin
               unique case (pos)
                  3'd0:    b = ChrAmp;
                  3'd1:    b = ChrQ;
                  3'd2:    b = ChrU;
                  3'd3:    b = ChrO;
                  3'd4:    b = ChrT;
                  default: b = ChrSemi;
               endcase
            end
            CHR_AMP: begin
               unique case (pos)
                  3'd0:    b = ChrAmp;
                  3'd1:    b = ChrA;
                  3'd2:    b = ChrM;
                  3'd3:    b = ChrP;
                  default: b = ChrSemi;
               endcase
            end
            CHR_LT: begin
               unique case (pos)
                  3'd0:    b = ChrAmp;
                  3'd1:    b = ChrL;
                  3'd2:    b = ChrT;
                  default: b = ChrSemi;
               endcase
            end
            CHR_GT: begin
               unique case (pos)
                  3'd0:    b = ChrAmp;
                  3'd1:    b = ChrG;
                  3'd2:    b = ChrT;
                  default: b = ChrSemi;
               endcase
            end
            default: b = txt;
         endcase
         return b;
      end
   endfunction

endpackage

`default_nettype wire

FILE: rtl/fortune_quote_splitter_core.sv
`default_nettype none

// Fortune-file quote splitter. Each req word carries one text byte; the block renders it
// as zero or more rsp words: text bytes (tuser 0) and quote-end markers (tuser 1), with
// tlast on the last word caused by each req word. A percent sign after a newline ends a
// quote, a newline inside a quote becomes <br>, and with csr_wdata set to 1 the characters
// " & < > become HTML entities. Carriage returns are dropped. Results leave one per cycle
// through the output register unless rsp_tready stalls. A plain byte makes 1 result,
// an entity 4 to 6, a pending line break adds 4 and a quote end adds 1, up to 11.
// Words that make no result are taken at one per cycle while no earlier word is held.
module fortune_quote_splitter_core (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_we,
   input  wire logic       csr_wdata,    // escape_markup
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,    // [7:0] text_byte
   input  wire logic       req_tlast,    // end_of_text
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,    // [7:0] out_byte
   output logic            rsp_tuser,    // item_kind
   output logic            rsp_tlast     // run_last
);

   fqs_pkg::plan_type plan;

   fqs_parse u_parse (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .accept      (req_tvalid && req_tready),
      .text_byte   (req_tdata),
      .end_of_text (req_tlast),
      .plan        (plan)
   );

   fqs_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .plan       (plan),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

FILE: rtl/fqs_parse.sv
`default_nettype none

module fqs_parse (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_we,
   input  wire logic             csr_wdata,
   input  wire logic             accept,
   input  wire logic [7:0]       text_byte,
   input  wire logic             end_of_text,
   output fqs_pkg::plan_type     plan
);

   typedef enum logic [1:0] {
      MODE_TEXT      = 2'd0,
      MODE_NEWLINE   = 2'd1,
      MODE_AFTER_END = 2'd2
   } mode_type;

   logic     escape_ff;
   mode_type mode_ff, mode_in;
   logic     quote_ff, quote_in;
   fqs_pkg::chr_type cls;

   // Classify the incoming character for rendering
   always_comb begin
      cls = fqs_pkg::CHR_BYTE;
      if (text_byte == fqs_pkg::ChrLf) begin
         cls = fqs_pkg::CHR_BR;
      end else if (escape_ff) begin
         priority if (text_byte == fqs_pkg::ChrDquot) cls = fqs_pkg::CHR_QUOT;
         else if (text_byte == fqs_pkg::ChrAmp) cls = fqs_pkg::CHR_AMP;
         else if (text_byte == fqs_pkg::ChrLt) cls = fqs_pkg::CHR_LT;
         else if (text_byte == fqs_pkg::ChrGt) cls = fqs_pkg::CHR_GT;
         else cls = fqs_pkg::CHR_BYTE;
      end
   end

   // Decode the word against the parse state
   always_comb begin
      plan.br_pre   = 1'b0;
      plan.chr      = fqs_pkg::CHR_NONE;
      plan.txt      = text_byte;
      plan.end_mark = 1'b0;
      mode_in       = mode_ff;
      quote_in      = quote_ff;
      if (text_byte != fqs_pkg::ChrCr) begin
         unique case (mode_ff)
            MODE_NEWLINE: begin
               if (text_byte == fqs_pkg::ChrPct) begin
                  plan.end_mark = 1'b1;
                  quote_in      = 1'b0;
                  mode_in       = MODE_AFTER_END;
               end else begin
                  mode_in     = MODE_TEXT;
                  plan.br_pre = 1'b1;
                  plan.chr    = cls;
                  quote_in    = 1'b1;
               end
            end
            MODE_AFTER_END: begin
               if (text_byte != fqs_pkg::ChrLf && text_byte != fqs_pkg::ChrPct) begin
                  mode_in  = MODE_TEXT;
                  plan.chr = cls;
                  quote_in = 1'b1;
               end
            end
            default: begin
               if (text_byte == fqs_pkg::ChrLf) begin
                  mode_in = MODE_NEWLINE;
               end else begin
                  plan.chr = cls;
                  quote_in = 1'b1;
               end
            end
         endcase
      end
      // Close a non-empty quote on the final word and restart
      if (end_of_text) begin
         if (quote_in) plan.end_mark = 1'b1;
         mode_in  = MODE_TEXT;
         quote_in = 1'b0;
      end
   end

   // Hold parse state and the escape setting
   always_ff @(posedge clock) begin
      if (reset) begin
         escape_ff <= 1'b0;
         mode_ff   <= MODE_TEXT;
         quote_ff  <= 1'b0;
      end else begin
         if (csr_we) escape_ff <= csr_wdata;
         if (accept) begin
            mode_ff  <= mode_in;
            quote_ff <= quote_in;
         end
      end
   end

endmodule

`default_nettype wire

FILE: rtl/fqs_emit.sv
`default_nettype none

module fqs_emit (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  wire fqs_pkg::plan_type plan,
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output logic [7:0]            rsp_tdata,
   output logic                  rsp_tuser,
   output logic                  rsp_tlast
);

   fqs_pkg::plan_type plan_ff;
   logic       plan_vld_ff;
   logic [3:0] idx_ff;
   logic       rsp_vld_ff;
   logic [7:0] data_ff, data_in;
   logic       kind_ff, kind_in;
   logic       last_ff;

   logic [3:0] pre_n, chr_n, cur_len, rel;
   logic       out_free, step, is_last, done, accept, new_has;

   // Work out the current item of the held plan
   always_comb begin
      pre_n   = plan_ff.br_pre ? 4'd4 : 4'd0;
      chr_n   = fqs_pkg::chr_len(plan_ff.chr);
      cur_len = pre_n + chr_n + {3'd0, plan_ff.end_mark};
      rel     = idx_ff - pre_n;
      is_last = (idx_ff == cur_len - 4'd1);
      kind_in = fqs_pkg::KindText;
      data_in = 8'd0;
      priority if (idx_ff < pre_n) begin
         data_in = fqs_pkg::chr_at(fqs_pkg::CHR_BR, idx_ff[2:0], plan_ff.txt);
      end else if (rel < chr_n) begin
         data_in = fqs_pkg::chr_at(plan_ff.chr, rel[2:0], plan_ff.txt);
      end else begin
         kind_in = fqs_pkg::KindQuoteEnd;
      end
   end

   // Handshake: advance when the output register can take a word
   assign out_free   = !rsp_vld_ff || rsp_tready;
   assign step       = plan_vld_ff && out_free;
   assign done       = step && is_last;
   assign req_tready = !plan_vld_ff || done;
   assign accept     = req_tvalid && req_tready;
   assign new_has    = plan.br_pre || (plan.chr != fqs_pkg::CHR_NONE) || plan.end_mark;

   // Hold the plan and step through its items
   always_ff @(posedge clock) begin
      if (reset) begin
         plan_vld_ff <= 1'b0;
         idx_ff      <= 4'd0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         if (accept && new_has) begin
            plan_vld_ff <= 1'b1;
            idx_ff      <= 4'd0;
         end else if (done) begin
            plan_vld_ff <= 1'b0;
         end else if (step) begin
            idx_ff <= idx_ff + 4'd1;
         end
         if (step) rsp_vld_ff <= 1'b1;
         else if (rsp_tready) rsp_vld_ff <= 1'b0;
      end
   end

   // Load payload registers
   always_ff @(posedge clock) begin
      if (accept && new_has) plan_ff <= plan;
      if (step) begin
         data_ff <= data_in;
         kind_ff <= kind_in;
         last_ff <= is_last;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = kind_ff;
   assign rsp_tlast  = last_ff;

   // A held plan always has at least one item
   assert property (@(posedge clock) disable iff (reset) plan_vld_ff |-> cur_len != 4'd0)
      else $error("empty plan held");

   // The item index stays inside the plan
   assert property (@(posedge clock) disable iff (reset) plan_vld_ff |-> idx_ff < cur_len)
      else $error("item index past plan end");

   // A quote end closes the run of its word and carries a zero byte
   assert property (@(posedge clock) disable iff (reset)
                    rsp_vld_ff && kind_ff == fqs_pkg::KindQuoteEnd |-> last_ff && data_ff == 8'd0)
      else $error("quote end not last or not zero");

   // No new word is taken while a plan still has items to send
   assert property (@(posedge clock) disable iff (reset)
                    plan_vld_ff && !is_last |-> !req_tready)
      else $error("word taken mid-plan");

endmodule

`default_nettype wire

FILE: tb/fortune_quote_splitter_core_tb.sv
`default_nettype none

module fortune_quote_splitter_core_tb;

   localparam int CycleLimit  = 300000;
   localparam int SettleTicks = 16;
   localparam int HoldCycles  = 400;

   typedef enum logic [1:0] {
      MODE_TEXT      = 2'd0,
      MODE_AFTER_LF  = 2'd1,
      MODE_AFTER_END = 2'd2
   } split_mode_type;

   typedef struct packed {
      logic [7:0] text;
      logic       eot;
   } text_item_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] data;
      logic       last_word;
   } quote_word_type;

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       csr_we     = 1'b0;
   logic       csr_wdata  = 1'b0;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;
   logic       req_tlast  = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic       rsp_tuser;
   logic       rsp_tlast;

   fortune_quote_splitter_core dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   // Splitter state as predicted from the accepted words
   split_mode_type split_mode   = MODE_TEXT;
   logic           quote_filled = 1'b0;
   logic           escape_on    = 1'b0;

   text_item_type  pending_q[$];
   quote_word_type quote_words_q[$];
   quote_word_type run_q[$];
   logic [7:0]     text_buf[$];

   int  mismatch_count = 0;
   int  cycle_count    = 0;
   bit  hold_request   = 1'b0;

   // Append one word to the run caused by the current input word
   task automatic add_word(input logic kind, input logic [7:0] b);
      quote_word_type w;
      w.kind      = kind;
      w.data      = b;
      w.last_word = 1'b0;
      run_q.push_back(w);
   endtask

   task automatic add_string(input string s);
      for (int i = 0; i < s.len(); i++)
         add_word(fqs_pkg::KindText, s[i]);
      quote_filled = 1'b1;
   endtask

   // Render one character inside a quote
   task automatic add_char(input logic [7:0] b);
      if (b == fqs_pkg::ChrLf)
         add_string("<br>");
      else if (escape_on && b == fqs_pkg::ChrDquot)
         add_string("&quot;");
      else if (escape_on && b == fqs_pkg::ChrAmp)
         add_string("&amp;");
      else if (escape_on && b == fqs_pkg::ChrLt)
         add_string("&lt;");
      else if (escape_on && b == fqs_pkg::ChrGt)
         add_string("&gt;");
      else begin
         add_word(fqs_pkg::KindText, b);
         quote_filled = 1'b1;
      end
   endtask

   // Work out the words that one accepted text byte produces
   task automatic predict_split(input logic [7:0] b, input logic eot);
      quote_word_type w;
      run_q.delete();
      if (b != fqs_pkg::ChrCr) begin
         case (split_mode)
            MODE_AFTER_LF: begin
               if (b == fqs_pkg::ChrPct) begin
                  add_word(fqs_pkg::KindQuoteEnd, 8'h00);
                  quote_filled = 1'b0;
                  split_mode   = MODE_AFTER_END;
               end else begin
                  split_mode = MODE_TEXT;
                  add_string("<br>");
                  add_char(b);
               end
            end
            MODE_AFTER_END: begin
               if (b != fqs_pkg::ChrLf && b != fqs_pkg::ChrPct) begin
                  split_mode = MODE_TEXT;
                  add_char(b);
               end
            end
            default: begin
               if (b == fqs_pkg::ChrLf)
                  split_mode = MODE_AFTER_LF;
               else
                  add_char(b);
            end
         endcase
      end
      // Close a non-empty quote on the final byte and drop a pending newline
      if (eot) begin
         if (quote_filled)
            add_word(fqs_pkg::KindQuoteEnd, 8'h00);
         split_mode   = MODE_TEXT;
         quote_filled = 1'b0;
      end
      for (int i = 0; i < run_q.size(); i++) begin
         w           = run_q[i];
         w.last_word = (i == run_q.size() - 1);
         quote_words_q.push_back(w);
      end
   endtask

   // Driver: offer pending words in bursts with random gaps
   int burst_left = 1;
   int gap_left   = 0;

   always @(posedge clock) begin
      text_item_type item;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= 8'h00;
         req_tlast  <= 1'b0;
         burst_left = $urandom_range(1, 24);
         gap_left   = 0;
      end else begin
         if (req_tvalid && req_tready)
            predict_split(req_tdata, req_tlast);
         if (!req_tvalid || req_tready) begin
            if (gap_left != 0 || pending_q.size() == 0) begin
               if (gap_left != 0)
                  gap_left--;
               req_tvalid <= 1'b0;
            end else begin
               item = pending_q.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= item.text;
               req_tlast  <= item.eot;
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 24);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end else
                  burst_left--;
            end
         end
      end
   end

   // Monitor: stall on a shifting pattern, hold off once for a long stretch, check words
   int stall_tick = 0;
   int hold_left  = 0;
   bit hold_done  = 1'b0;

   always @(posedge clock) begin
      quote_word_type want;
      int             pattern;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (quote_words_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected word: kind %0d byte %02h last %0d",
                           rsp_tuser, rsp_tdata, rsp_tlast);
            end else begin
               want = quote_words_q.pop_front();
               if (rsp_tuser !== want.kind || rsp_tdata !== want.data ||
                   rsp_tlast !== want.last_word) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display({"mismatch: expected kind %0d byte %02h last %0d, ",
                               "got kind %0d byte %02h last %0d"},
                              want.kind, want.data, want.last_word,
                              rsp_tuser, rsp_tdata, rsp_tlast);
               end
            end
         end
         stall_tick++;
         pattern = (stall_tick / 64) % 4;
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (hold_request && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HoldCycles;
            rsp_tready <= 1'b0;
         end else begin
            case (pattern)
               0:       rsp_tready <= 1'b1;
               1:       rsp_tready <= ($urandom_range(0, 1) == 1);
               2:       rsp_tready <= ($urandom_range(0, 3) == 0);
               default: rsp_tready <= (stall_tick % 8 != 0);
            endcase
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
         $display("fortune_quote_splitter_core_tb NOT OK");
         $finish;
      end
   end

   task automatic queue_byte(input logic [7:0] b, input logic eot);
      text_item_type item;
      item.text = b;
      item.eot  = eot;
      pending_q.push_back(item);
   endtask

   // Move the buffered text to the pending words, end of text on the last byte
   task automatic flush_text();
      for (int i = 0; i < text_buf.size(); i++)
         queue_byte(text_buf[i], i == text_buf.size() - 1);
      text_buf.delete();
   endtask

   function automatic logic [7:0] pick_body_byte();
      int         r;
      logic [7:0] b;
      r = $urandom_range(0, 99);
      if (r < 45)
         b = 8'($urandom_range(8'h20, 8'h7e));
      else if (r < 60) begin
         case ($urandom_range(0, 3))
            0:       b = fqs_pkg::ChrDquot;
            1:       b = fqs_pkg::ChrAmp;
            2:       b = fqs_pkg::ChrLt;
            default: b = fqs_pkg::ChrGt;
         endcase
      end else if (r < 68)
         b = fqs_pkg::ChrLf;
      else if (r < 72)
         b = fqs_pkg::ChrCr;
      else if (r < 76)
         b = fqs_pkg::ChrPct;
      else if (r < 90)
         b = 8'($urandom_range(8'h80, 8'hff));
      else
         b = 8'($urandom_range(0, 255));
      return b;
   endfunction

   // Build well-formed fortune texts with random content, some noise between
   task automatic queue_random_texts(input int n_words);
      int added;
      int n_quotes;
      int body_len;
      added = 0;
      while (added < n_words) begin
         if ($urandom_range(0, 9) == 0) begin
            // noise: arbitrary bytes
            body_len = $urandom_range(1, 20);
            for (int k = 0; k < body_len; k++)
               text_buf.push_back(8'($urandom_range(0, 255)));
         end else begin
            n_quotes = $urandom_range(1, 4);
            for (int q = 0; q < n_quotes; q++) begin
               body_len = $urandom_range(0, 12);
               for (int k = 0; k < body_len; k++)
                  text_buf.push_back(pick_body_byte());
               case ($urandom_range(0, 9))
                  6: begin
                     text_buf.push_back(fqs_pkg::ChrCr); text_buf.push_back(fqs_pkg::ChrLf);
                     text_buf.push_back(fqs_pkg::ChrPct);
                     text_buf.push_back(fqs_pkg::ChrCr); text_buf.push_back(fqs_pkg::ChrLf);
                  end
                  7: begin
                     text_buf.push_back(fqs_pkg::ChrLf); text_buf.push_back(fqs_pkg::ChrPct);
                     text_buf.push_back(fqs_pkg::ChrPct); text_buf.push_back(fqs_pkg::ChrLf);
                     text_buf.push_back(fqs_pkg::ChrLf);
                  end
                  8: begin
                     text_buf.push_back(fqs_pkg::ChrLf); text_buf.push_back(fqs_pkg::ChrLf);
                  end
                  9: begin
                     text_buf.push_back(fqs_pkg::ChrLf); text_buf.push_back(fqs_pkg::ChrPct);
                  end
                  default: begin
                     text_buf.push_back(fqs_pkg::ChrLf); text_buf.push_back(fqs_pkg::ChrPct);
                     text_buf.push_back(fqs_pkg::ChrLf);
                  end
               endcase
            end
            // sometimes leave the text on a bare newline
            if ($urandom_range(0, 4) == 0)
               text_buf.push_back(fqs_pkg::ChrLf);
         end
         added += text_buf.size();
         flush_text();
      end
   endtask

   // Wait until every word is out, then let the block settle
   task automatic wait_idle();
      @(negedge clock);
      while (pending_q.size() != 0 || req_tvalid || quote_words_q.size() != 0)
         @(negedge clock);
      repeat (SettleTicks) @(negedge clock);
   endtask

   task automatic write_escape(input logic value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      escape_on = value;
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Escaping off: zero byte, top byte, raw markup, quote ends, skips, double break
      queue_byte(8'h00, 1'b0);
      queue_byte(8'hff, 1'b0);
      queue_byte(fqs_pkg::ChrDquot, 1'b0);
      queue_byte(fqs_pkg::ChrAmp, 1'b0);
      queue_byte(fqs_pkg::ChrLf, 1'b0);
      queue_byte(fqs_pkg::ChrPct, 1'b0);
      queue_byte(fqs_pkg::ChrLf, 1'b0);
      queue_byte(fqs_pkg::ChrPct, 1'b0);
      queue_byte(fqs_pkg::ChrCr, 1'b0);
      queue_byte(8'h41, 1'b0);
      queue_byte(fqs_pkg::ChrLf, 1'b0);
      queue_byte(fqs_pkg::ChrLf, 1'b0);
      queue_byte(fqs_pkg::ChrCr, 1'b1);
      // empty quote end, then a pending newline dropped at end of text
      queue_byte(fqs_pkg::ChrLf, 1'b0);
      queue_byte(fqs_pkg::ChrPct, 1'b0);
      queue_byte(8'h62, 1'b0);
      queue_byte(fqs_pkg::ChrLf, 1'b1);
      wait_idle();

      // Escaping on: every entity, break before an entity, quote end
      write_escape(1'b1);
      queue_byte(fqs_pkg::ChrDquot, 1'b0);
      queue_byte(fqs_pkg::ChrAmp, 1'b0);
      queue_byte(fqs_pkg::ChrLt, 1'b0);
      queue_byte(fqs_pkg::ChrGt, 1'b0);
      queue_byte(fqs_pkg::ChrLf, 1'b0);
      queue_byte(fqs_pkg::ChrLt, 1'b0);
      queue_byte(fqs_pkg::ChrLf, 1'b0);
      queue_byte(fqs_pkg::ChrPct, 1'b0);
      queue_byte(8'h7f, 1'b1);
      wait_idle();

      // Random texts under both settings, with one long receiver hold-off
      write_escape(1'b0);
      queue_random_texts(60);
      wait_idle();
      write_escape(1'b1);
      hold_request = 1'b1;
      queue_random_texts(60);
      wait_idle();
      write_escape(1'b0);
      queue_random_texts(60);
      wait_idle();
      write_escape(1'b1);
      queue_random_texts(60);
      wait_idle();

      if (mismatch_count == 0 && quote_words_q.size() == 0)
         $display("fortune_quote_splitter_core_tb OK");
      else
         $display("fortune_quote_splitter_core_tb NOT OK");
      $finish;
   end

endmodule

`default_nettype wire

FILE: files.f
rtl/fqs_pkg.sv
rtl/fqs_parse.sv
rtl/fqs_emit.sv
rtl/fortune_quote_splitter_core.sv
tb/fortune_quote_splitter_core_tb.sv
